// ===== hw/rtl/mpjw_pkg.sv =====
// ----------------------------------------------------------------------------
// mpjw_pkg: shared constants, types and cosine table builder
// Widths of the phase accumulator, the sample format and the cosine table
// contents used by the phase-jump wavetable oscillator.
// ----------------------------------------------------------------------------
package mpjw_pkg;

  // table and number formats
  localparam int TABLE_DEPTH     = 512;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int PHASE_FRAC_BITS = 23;
  localparam int IDX_W           = $clog2(TABLE_DEPTH);
  localparam int PHASE_W         = IDX_W + PHASE_FRAC_BITS;

  // random word and configuration widths
  localparam int WORD_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'b1;

  localparam logic [CFG_W-1:0] THRESH_RESET = '1;

  // quarter turn in Q30 radians
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef logic signed [SAMPLE_WIDTH-1:0] cos_rom_t [TABLE_DEPTH];

  // unsigned long division by shift and subtract, table build only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // taylor series of cos (odd clear) or sin (odd set), Q30 in and out
  function automatic logic signed [63:0] taylor_q30(logic [63:0] x, logic odd);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        denom;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = odd ? x : ONE_Q30;
    sum  = $signed(term);
    for (int n = 1; n <= 12; n++) begin
      denom = 64'(2 * n - 1 + int'(odd)) * 64'(2 * n + int'(odd));
      term  = udiv64((term * x2) >> 30, denom);
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    return sum;
  endfunction

  // one table entry, cos(2*pi*i/depth) rounded and saturated
  function automatic logic signed [SAMPLE_WIDTH-1:0] cos_entry(int i);
    logic [63:0]        u;
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        x;
    logic signed [63:0] c;
    logic signed [63:0] mag;
    logic signed [63:0] maxv;
    u    = 64'(i) << (30 - IDX_W);
    quad = u[29:28];
    r    = {36'd0, u[27:0]};
    x    = (r * HALF_PI_Q30) >> 28;
    c    = taylor_q30(x, quad[0]);
    maxv = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    if (c < 0) begin
      c = 0;
    end
    if (c > $signed(ONE_Q30)) begin
      c = $signed(ONE_Q30);
    end
    mag = $signed(($unsigned(c) + (64'd1 << (30 - SAMPLE_WIDTH))) >> (31 - SAMPLE_WIDTH));
    if (mag > maxv) begin
      mag = maxv;
    end
    if (quad == 2'd1 || quad == 2'd2) begin
      mag = -mag;
    end
    return mag[SAMPLE_WIDTH-1:0];
  endfunction

  // whole table, worked out at elaboration
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t t;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      t[i] = cos_entry(i);
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/mpjw_if.sv =====
// ----------------------------------------------------------------------------
// mpjw_if: word channels of the oscillator
// Random word channel in, sample channel out, valid/ready handshake.
// ----------------------------------------------------------------------------

// random word channel
interface mpjw_in_if;
  logic                        valid;
  logic                        ready;
  logic [mpjw_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// interpolated sample channel
interface mpjw_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [mpjw_pkg::SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== hw/rtl/markov_phase_jump_wavetable_osc_unit.sv =====
// ----------------------------------------------------------------------------
// markov_phase_jump_wavetable_osc_unit: phase-jump wavetable oscillator
// Per word: multiply, phase advance, two table reads, interpolation multiply,
// output; a new word waits until the output state is left. One multiplier is
// shared by phase step and interpolation; the two table reads use one port.
// Reset (synchronous, active low): phase 0, step 0, threshold all ones.
// The cosine table is a constant and needs no fill after reset.
// ----------------------------------------------------------------------------
module markov_phase_jump_wavetable_osc_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  mpjw_in_if.sink                       in_ch,
  mpjw_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [mpjw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpjw_pkg::CFG_W-1:0]    cfg_data
);

  localparam int IDX_W   = mpjw_pkg::IDX_W;
  localparam int FRAC_W  = mpjw_pkg::PHASE_FRAC_BITS;
  localparam int PHASE_W = mpjw_pkg::PHASE_W;
  localparam int SW      = mpjw_pkg::SAMPLE_WIDTH;
  localparam int EXT_W   = (PHASE_W > mpjw_pkg::CFG_W) ? PHASE_W : mpjw_pkg::CFG_W;
  localparam int MA_W    = PHASE_W + 1;
  localparam int MB_W    = ((IDX_W > SW) ? IDX_W : SW) + 1;
  localparam int PROD_W  = MA_W + MB_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ADV, S_RD1, S_RD2, S_MUL2, S_OUT
  } state_t;

  state_t                       state_r;
  logic [mpjw_pkg::CFG_W-1:0]   step_r;
  logic [mpjw_pkg::CFG_W-1:0]   thresh_r;
  logic [PHASE_W-1:0]           phase_r;
  logic [IDX_W-1:0]             mult_k_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [SW-1:0]         s1_r;
  logic                         out_valid_r;
  logic signed [SW-1:0]         out_sample_r;

  logic                         in_acc;
  logic                         jump;
  logic [EXT_W-1:0]             step_ext;
  logic [PHASE_W-1:0]           step_eff;
  logic [IDX_W-1:0]             rom_addr;
  logic signed [SW-1:0]         rom_q;
  logic signed [SW:0]           diff;
  logic signed [MA_W-1:0]       mul_a;
  logic signed [MB_W-1:0]       mul_b;
  logic signed [PROD_W-1:0]     mul_p;
  logic signed [PROD_W-1:0]     rnd;
  logic signed [PROD_W-1:0]     quot;
  logic signed [SW-1:0]         interp;

  // handshake
  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;

  // jump decision and step reduced modulo one table period
  assign jump     = in_ch.random_word > thresh_r;
  assign step_ext = EXT_W'(step_r);
  assign step_eff = step_ext[PHASE_W-1:0];

  // table reads: current index, then its neighbour
  assign rom_addr = (state_r == S_RD2) ? phase_r[PHASE_W-1:FRAC_W] + IDX_W'(1)
                                       : phase_r[PHASE_W-1:FRAC_W];

  mpjw_cos_rom u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  // shared multiplier: phase step or interpolation slope
  assign diff = (SW+1)'(rom_q) - (SW+1)'(s1_r);

  always_comb begin
    if (state_r == S_MUL2) begin
      mul_a = $signed({1'b0, IDX_W'(0), phase_r[FRAC_W-1:0]});
      mul_b = MB_W'(diff);
    end else begin
      mul_a = $signed({1'b0, step_eff});
      mul_b = $signed(MB_W'(mult_k_r));
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // round half up and add to the lower entry
  assign rnd    = prod_r + (PROD_W'(1) <<< (FRAC_W - 1));
  assign quot   = rnd >>> FRAC_W;
  assign interp = s1_r + quot[SW-1:0];

  // sequencer, registers and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      thresh_r    <= mpjw_pkg::THRESH_RESET;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mpjw_pkg::REG_STEP:   step_r   <= cfg_data;
          mpjw_pkg::REG_THRESH: thresh_r <= cfg_data;
          default: ;
        endcase
      end
      // output word: load from the last step, clear once taken
      if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
        out_sample_r <= interp;
        out_valid_r  <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            mult_k_r <= jump ? in_ch.random_word[IDX_W-1:0] : IDX_W'(1);
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_ADV;
        end
        S_ADV: begin
          phase_r <= phase_r + prod_r[PHASE_W-1:0];
          state_r <= S_RD1;
        end
        S_RD1: begin
          state_r <= S_RD2;
        end
        S_RD2: begin
          s1_r    <= rom_q;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= mul_p;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // no second word is taken while one is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("word accepted while busy");

  // a new sample word appears only out of the output state
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("sample word without interpolation");

  // phase moves only in the advance step
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_ADV |=> $stable(phase_r))
    else $error("phase changed outside advance step");

endmodule

// ===== hw/rtl/mpjw_cos_rom.sv =====
// ----------------------------------------------------------------------------
// mpjw_cos_rom: cosine table with registered read
// One read port; data appears the cycle after the address.
// ----------------------------------------------------------------------------
module mpjw_cos_rom (
  input  logic                                     clk,
  input  logic [mpjw_pkg::IDX_W-1:0]               rd_addr,
  output logic signed [mpjw_pkg::SAMPLE_WIDTH-1:0] rd_data
);

  localparam mpjw_pkg::cos_rom_t ROM_TABLE = mpjw_pkg::build_cos_rom();

  logic signed [mpjw_pkg::SAMPLE_WIDTH-1:0] rd_data_r;

  // registered table read
  always_ff @(posedge clk) begin
    rd_data_r <= ROM_TABLE[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== test/markov_phase_jump_wavetable_osc_unit_test.sv =====
// ----------------------------------------------------------------------------
// markov_phase_jump_wavetable_osc_unit_test: phase-jump oscillator testbench
// Sends random words through the input channel and checks every interpolated
// sample against a local phase accumulator and cosine table. Starts with a
// short directed run over the quarter turns, the jump rule and the register
// extremes, then runs random phases with new step and threshold settings,
// bursty input traffic and a receiver that stalls, once for a long stretch.
// ----------------------------------------------------------------------------
module markov_phase_jump_wavetable_osc_unit_test;
  import mpjw_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 12;
  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 170;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 400;
  localparam int DIR_ROWS_N   = 22;

  // quarter turn in Q30 radians, for the table build
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  // directed row: optional register load, then one word
  typedef struct packed {
    bit                        load;
    logic [CFG_W-1:0]          step;
    logic [CFG_W-1:0]          thresh;
    logic [WORD_W-1:0]         word;
    bit                        pinned;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // reset state: phase stays at zero, top of the cosine
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,  16'sd32767},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,  16'sd32767},
    // quarter-turn steps, never a jump
    '{1'b1, 32'h4000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1,  16'sd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, -16'sd32767},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,  16'sd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1,  16'sd32767},
    // zero threshold: every word but zero jumps
    '{1'b1, 32'h4000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,  16'sd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1, -16'sd32767},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0003, 1'b1,  16'sd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0200, 1'b1,  16'sd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,  16'sd32767},
    // full-scale step and threshold
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0,  16'sd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0,  16'sd0},
    // words either side of a mid threshold
    '{1'b1, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 1'b0,  16'sd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h8000_0001, 1'b0,  16'sd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h8000_01FF, 1'b0,  16'sd0},
    // fractional step, interpolation between entries
    '{1'b1, 32'h00C0_0000, 32'h7FFF_FFFF, 32'h5555_5555, 1'b0,  16'sd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'hAAAA_AAAA, 1'b0,  16'sd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0100, 1'b0,  16'sd0},
    // zero step: the same sample repeats
    '{1'b1, 32'h0000_0000, 32'h0000_0000, 32'hDEAD_BEEF, 1'b0,  16'sd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,  16'sd0},
    '{1'b1, 32'h0080_0001, 32'h0000_0000, 32'hFFFF_FE00, 1'b0,  16'sd0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  mpjw_in_if  word_ch ();
  mpjw_out_if sample_ch ();

  markov_phase_jump_wavetable_osc_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (word_ch),
    .out_ch    (sample_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the oscillator
  logic signed [SAMPLE_WIDTH-1:0] cos_lut [TABLE_DEPTH];
  logic [CFG_W-1:0]               osc_step;
  logic [CFG_W-1:0]               osc_thresh;
  logic [PHASE_W-1:0]             osc_phase;
  logic signed [SAMPLE_WIDTH-1:0] exp_sample;

  logic signed [SAMPLE_WIDTH-1:0] sample_due [$];
  int unsigned                    mismatches;
  int unsigned                    words_in;
  int unsigned                    stall_cycles;

  // sender side
  bit                             drv_pinned;
  logic signed [SAMPLE_WIDTH-1:0] drv_pin_val;
  int unsigned                    burst_left;
  bit                             sender_gaps;
  logic [CFG_W-1:0]               cur_thresh;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // taylor sum of cos (odd clear) or sin (odd set), Q30
  function automatic longint series_q30(longint unsigned x, bit odd);
    longint unsigned sq;
    longint unsigned term;
    longint unsigned div;
    longint          acc;
    sq   = (x * x) >> 30;
    term = odd ? x : (64'd1 << 30);
    acc  = longint'(term);
    for (int k = 1; k <= 12; k++) begin
      div  = longint'(2 * k - 1 + int'(odd)) * longint'(2 * k + int'(odd));
      term = ((term * sq) >> 30) / div;
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return acc;
  endfunction

  // build the cosine table, one quadrant picked per entry
  task automatic fill_cos_lut();
    longint unsigned angle;
    longint unsigned x;
    longint          c;
    longint          mag;
    logic [1:0]      quad;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      angle = longint'(i) << (30 - IDX_W);
      quad  = angle[29:28];
      x     = ((angle & 64'h0FFF_FFFF) * QUARTER_TURN_Q30) >> 28;
      c     = series_q30(x, quad[0]);
      if (c < 0) c = 0;
      if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
      mag = (c + (64'sd1 <<< (30 - SAMPLE_WIDTH))) >>> (31 - SAMPLE_WIDTH);
      if (mag > (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1) begin
        mag = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
      end
      if (quad == 2'd1 || quad == 2'd2) mag = -mag;
      cos_lut[i] = mag[SAMPLE_WIDTH-1:0];
    end
  endtask

  // advance the phase for one word and interpolate the new sample
  function automatic logic signed [SAMPLE_WIDTH-1:0] predict_sample(logic [WORD_W-1:0] w);
    logic [PHASE_W-1:0]         adv;
    logic [IDX_W-1:0]           idx;
    logic [IDX_W-1:0]           nxt;
    logic [PHASE_FRAC_BITS-1:0] frac;
    longint                     s1;
    longint                     v;
    longint                     res;
    if (w <= osc_thresh) begin
      adv = osc_step;
    end else begin
      adv = osc_step * {{(PHASE_W - IDX_W){1'b0}}, w[IDX_W-1:0]};
    end
    osc_phase = osc_phase + adv;
    idx  = osc_phase[PHASE_W-1:PHASE_FRAC_BITS];
    nxt  = idx + IDX_W'(1);
    frac = osc_phase[PHASE_FRAC_BITS-1:0];
    s1   = cos_lut[idx];
    v    = (longint'(cos_lut[nxt]) - s1) * longint'(frac)
           + (64'sd1 <<< (PHASE_FRAC_BITS - 1));
    res  = s1 + (v >>> PHASE_FRAC_BITS);
    return res[SAMPLE_WIDTH-1:0];
  endfunction

  // monitor: register copy, prediction, checking, watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      osc_step   = '0;
      osc_thresh = THRESH_RESET;
      osc_phase  = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_STEP) begin
          osc_step = cfg_data;
        end else if (cfg_index == REG_THRESH) begin
          osc_thresh = cfg_data;
        end
      end
      // result word against the oldest expectation
      if (sample_ch.valid && sample_ch.ready) begin
        if (sample_due.size() == 0) begin
          $error("sample_out: expected none, actual %0d", sample_ch.sample_out);
          mismatches++;
        end else if (sample_ch.sample_out !== sample_due[0]) begin
          $error("sample_out: expected %0d, actual %0d", sample_due[0], sample_ch.sample_out);
          mismatches++;
          void'(sample_due.pop_front());
        end else begin
          void'(sample_due.pop_front());
        end
      end
      // accepted input word, phase always advanced
      if (word_ch.valid && word_ch.ready) begin
        exp_sample = predict_sample(word_ch.random_word);
        sample_due.push_back(drv_pinned ? drv_pin_val : exp_sample);
        words_in++;
      end
    end
    if ((word_ch.valid && word_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: changing stall patterns, one long hold-off mid-run
  initial begin : sample_receiver
    int unsigned hold_left;
    int unsigned tick;
    bit          hold_done;
    sample_ch.ready = 1'b0;
    hold_left = 0;
    tick      = 0;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      tick++;
      if (!hold_done && words_in >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        sample_ch.ready <= 1'b0;
      end else begin
        case ((tick / 300) % 4)
          0:       sample_ch.ready <= 1'b1;
          1:       sample_ch.ready <= 1'($urandom_range(0, 1));
          2:       sample_ch.ready <= ($urandom_range(0, 9) != 0);
          default: sample_ch.ready <= (tick % 5 != 0) && (tick % 7 != 0);
        endcase
      end
    end
  end

  // offer one word in bursts, return at the falling edge after acceptance
  task automatic send_word(logic [WORD_W-1:0] w, bit pin, logic signed [SAMPLE_WIDTH-1:0] pv);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (!sender_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        word_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    word_ch.valid       <= 1'b1;
    word_ch.random_word <= w;
    drv_pinned          <= pin;
    drv_pin_val         <= pv;
    do @(posedge clk); while (!word_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  // stop offering and wait until every sample has come back
  task automatic drain_samples();
    word_ch.valid <= 1'b0;
    burst_left = 0;
    while (sample_due.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // load both registers while the block is idle
  task automatic load_regs(logic [CFG_W-1:0] step, logic [CFG_W-1:0] thresh);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP;
    cfg_data  <= step;
    @(negedge clk);
    cfg_index <= REG_THRESH;
    cfg_data  <= thresh;
    @(negedge clk);
    cfg_we     <= 1'b0;
    cur_thresh = thresh;
    @(negedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    logic [CFG_W-1:0]  st;
    logic [CFG_W-1:0]  th;
    logic [WORD_W-1:0] w;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    word_ch.valid       = 1'b0;
    word_ch.random_word = '0;
    drv_pinned          = 1'b0;
    drv_pin_val         = '0;
    burst_left          = 0;
    sender_gaps         = 1'b1;
    cur_thresh          = THRESH_RESET;
    mismatches          = 0;
    words_in            = 0;
    stall_cycles        = 0;
    fill_cos_lut();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    for (int r = 0; r < DIR_ROWS_N; r++) begin
      if (DIR_ROWS[r].load) begin
        drain_samples();
        load_regs(DIR_ROWS[r].step, DIR_ROWS[r].thresh);
      end
      send_word(DIR_ROWS[r].word, DIR_ROWS[r].pinned, DIR_ROWS[r].sample);
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_samples();
      case (ph)
        0: begin st = $urandom_range(1, 32'h00FF_FFFF); th = THRESH_RESET; end
        1: begin st = 32'hFFFF_FFFF; th = '0; end
        2: begin st = '0; th = $urandom; end
        default: begin
          case ($urandom_range(0, 4))
            0:       st = '0;
            1:       st = 32'hFFFF_FFFF;
            2:       st = $urandom_range(1, 32'h00FF_FFFF);
            3:       st = {IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                           {PHASE_FRAC_BITS{1'b0}}};
            default: st = $urandom;
          endcase
          case ($urandom_range(0, 3))
            0:       th = '0;
            1:       th = THRESH_RESET;
            2:       th = 32'h8000_0000 ^ $urandom_range(0, 255);
            default: th = $urandom;
          endcase
        end
      endcase
      load_regs(st, th);
      sender_gaps = (ph % 3 != 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // words on and around the threshold, and with the jump field at its ends
        case ($urandom_range(0, 9))
          0:       w = cur_thresh;
          1:       w = cur_thresh + CFG_W'(1);
          2:       w = $urandom & ~32'h0000_01FF;
          3:       w = $urandom | 32'h0000_01FF;
          default: w = $urandom;
        endcase
        send_word(w, 1'b0, '0);
      end
    end

    drain_samples();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mpjw_pkg.sv
hw/rtl/mpjw_if.sv
hw/rtl/mpjw_cos_rom.sv
hw/rtl/markov_phase_jump_wavetable_osc_unit.sv
test/markov_phase_jump_wavetable_osc_unit_test.sv
